@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the queue, divider and front RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ rtl/core/gdbd_pkg.sv @@
`default_nettype none

package gdbd_pkg;

    // Q1.15 unity gain and the register defaults.
    localparam logic [15:0] UNITY_Q15      = 16'h8000;
    localparam logic [11:0] DEF_IMAGE_DIM  = 12'd1;
    localparam logic [15:0] DEF_MAX_DARKEN = 16'd26214;

    // Configuration port layout.
    localparam int CFG_DIM_W  = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DARKEN   = 2'd2;

    // Queue depths between front and back and at the output.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 2;

    // Dither scaling: offset = round(BAYER_SCALE * b / BAYER_MAX) - DITHER_BIAS.
    localparam int BAYER_SCALE = 2048;
    localparam int BAYER_MAX   = 63;
    localparam int DITHER_BIAS = 1024;

    // 8x8 Bayer matrix, indexed by {row[2:0], column[2:0]}.
    typedef logic [5:0] t_bayer_tab [64];
    localparam t_bayer_tab BAYER_TAB = '{
        6'd0,  6'd48, 6'd12, 6'd60, 6'd3,  6'd51, 6'd15, 6'd63,
        6'd32, 6'd16, 6'd44, 6'd28, 6'd35, 6'd19, 6'd47, 6'd31,
        6'd8,  6'd56, 6'd4,  6'd52, 6'd11, 6'd59, 6'd7,  6'd55,
        6'd40, 6'd24, 6'd36, 6'd20, 6'd43, 6'd27, 6'd39, 6'd23,
        6'd2,  6'd50, 6'd14, 6'd62, 6'd1,  6'd49, 6'd13, 6'd61,
        6'd34, 6'd18, 6'd46, 6'd30, 6'd33, 6'd17, 6'd45, 6'd29,
        6'd10, 6'd58, 6'd6,  6'd54, 6'd9,  6'd57, 6'd5,  6'd53,
        6'd42, 6'd26, 6'd38, 6'd22, 6'd41, 6'd25, 6'd37, 6'd21
    };

    // Signed dither offset in 1/256 steps for each matrix position.
    typedef logic signed [11:0] t_dith_tab [64];

    function automatic t_dith_tab build_dither();
        t_dith_tab tab;
        int        b;
        for (int i = 0; i < 64; i++) begin
            b      = int'(BAYER_TAB[i]);
            tab[i] = 12'((BAYER_SCALE * b + BAYER_MAX / 2) / BAYER_MAX - DITHER_BIAS);
        end
        return tab;
    endfunction

    localparam t_dith_tab DITHER_TAB = build_dither();

    // Request passed from the front to the back.
    typedef struct packed {
        logic [15:0] pixel;
        logic [2:0]  by;
        logic [2:0]  bx;
        logic        fade;
        logic        frame_end;
        logic [15:0] factor;
    } t_mid;

    // Finished result.
    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_end;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/core/gdbd_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"

module gdbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_rd,
    output logic [WIDTH-1:0]      o_rdata,
    output logic                  o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW:0]      n_count;

    // Status and head of the queue.
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + (AW+1)'(1);
        end else if (i_rd && !i_wr) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_wr && o_full && !i_rd, "write into full queue")
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_rd && o_empty, "read from empty queue")

endmodule

`default_nettype wire

@@ rtl/core/gdbd_div.sv @@
`default_nettype none
`include "assert_macros.svh"

// Row factor unit: factor = 1.0 - floor(k * md / span), one quotient bit per cycle.
module gdbd_div import gdbd_pkg::*; #(
    parameter int CW = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [CW-1:0] i_k,
    input  wire logic [CW-1:0] i_span,
    input  wire logic [15:0]   i_md,
    output logic               o_busy,
    output logic [15:0]        o_factor
);

    localparam int NW   = CW + 16;
    localparam int CNTW = $clog2(NW + 1);

    logic            r_busy;
    logic            r_mul;
    logic [CNTW-1:0] r_cnt;
    logic [15:0]     r_quo;
    logic [CW-1:0]   r_k;
    logic [CW-1:0]   r_span;
    logic [15:0]     r_md;
    logic [NW-1:0]   r_num;
    logic [CW-1:0]   r_rem;

    logic [CW:0]     rem_sh;
    logic            ge;
    logic [CW-1:0]   n_rem;

    // One restoring step.
    assign rem_sh = {r_rem, r_num[NW-1]};
    assign ge     = (rem_sh >= {1'b0, r_span});
    assign n_rem  = ge ? CW'(rem_sh - {1'b0, r_span}) : rem_sh[CW-1:0];

    assign o_busy   = r_busy;
    assign o_factor = 16'(17'(UNITY_Q15) - {1'b0, r_quo});

    // Sequencing: operand capture, the multiply, then NW divide steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_cnt  <= '0;
            r_quo  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_mul  <= 1'b1;
        end else if (r_busy) begin
            if (r_mul) begin
                r_mul <= 1'b0;
                r_cnt <= CNTW'(NW);
            end else begin
                r_quo <= {r_quo[14:0], ge};
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands, product and partial remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_k    <= i_k;
            r_span <= i_span;
            r_md   <= i_md;
        end else if (r_busy && r_mul) begin
            r_num <= NW'({16'd0, r_k} * {{CW{1'b0}}, r_md});
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    `ASSERT_ALWAYS(a_quo_bound, i_clk, i_rst_n, $fell(r_busy) |-> (r_quo <= r_md), "quotient exceeds darkening")

endmodule

`default_nettype wire

@@ rtl/core/gdbd_front.sv @@
`default_nettype none
`include "assert_macros.svh"

// Front part: configuration, position counters, row factor and classification.
module gdbd_front import gdbd_pkg::*; #(
    parameter int MAX_DIM = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [15:0]           i_pixel_in,
    input  wire logic                  i_frame_start,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                       o_mid_wr,
    output t_mid                       o_mid_data,
    input  wire logic                  i_mid_full
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = CW + 1;

    logic [CFG_DIM_W-1:0] r_width;
    logic [CFG_DIM_W-1:0] r_height;
    logic [15:0]          r_md;
    logic [CW-1:0]        r_col;
    logic [CW-1:0]        r_row;
    logic [15:0]          r_row_factor;
    logic                 r_stg_vld;
    logic                 r_wait_div;
    t_mid                 r_stg;

    logic [DW-1:0] w_eff;
    logic [DW-1:0] h_eff;
    logic [DW-1:0] start;
    logic [DW-1:0] span;
    logic [DW-1:0] x_nxt;
    logic [DW-1:0] y_nxt;
    logic [DW-1:0] k_raw;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] k;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;
    logic [15:0]   md_sat;
    logic          fade;
    logic          row_end;
    logic          fr_end;
    logic          need_div;
    logic          accept;
    logic          stg_push;
    logic          div_start;
    logic          div_busy;
    logic [15:0]   div_factor;
    t_mid          n_stg;

    // Effective frame size: zero counts as one, large values clamp to MAX_DIM.
    always_comb begin
        if (r_width == '0) begin
            w_eff = DW'(1);
        end else if ({{(32-CFG_DIM_W){1'b0}}, r_width} > 32'(MAX_DIM)) begin
            w_eff = DW'(MAX_DIM);
        end else begin
            w_eff = DW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = DW'(1);
        end else if ({{(32-CFG_DIM_W){1'b0}}, r_height} > 32'(MAX_DIM)) begin
            h_eff = DW'(MAX_DIM);
        end else begin
            h_eff = DW'(r_height);
        end
    end

    // Position of the incoming pixel and its classification.
    assign x        = i_frame_start ? '0 : r_col;
    assign y        = i_frame_start ? '0 : r_row;
    assign start    = h_eff >> 2;
    assign span     = h_eff - start - DW'(1);
    assign fade     = ({1'b0, y} >= start);
    assign x_nxt    = {1'b0, x} + DW'(1);
    assign y_nxt    = {1'b0, y} + DW'(1);
    assign row_end  = (x_nxt >= w_eff);
    assign fr_end   = row_end && (y_nxt >= h_eff);
    assign k_raw    = {1'b0, y} - start;
    assign k        = (k_raw > span) ? span[CW-1:0] : k_raw[CW-1:0];
    assign md_sat   = (r_md > UNITY_Q15) ? UNITY_Q15 : r_md;
    assign need_div = (x == '0) && fade && (span != '0);

    // Handshake: the stage hands over to the queue once any divide is done and the queue has room.
    assign stg_push   = r_stg_vld && !r_wait_div && !i_mid_full;
    assign o_full     = r_stg_vld && !stg_push;
    assign accept     = i_push && !o_full;
    assign div_start  = accept && need_div;
    assign o_mid_wr   = stg_push;
    assign o_mid_data = r_stg;

    // Counter advance with row and frame wrap.
    always_comb begin
        if (row_end) begin
            n_col = '0;
            n_row = fr_end ? '0 : y_nxt[CW-1:0];
        end else begin
            n_col = x_nxt[CW-1:0];
            n_row = y;
        end
    end

    // Request captured into the stage.
    always_comb begin
        n_stg.pixel     = i_pixel_in;
        n_stg.by        = y[2:0];
        n_stg.bx        = x[2:0];
        n_stg.fade      = fade;
        n_stg.frame_end = fr_end;
        n_stg.factor    = (x == '0) ? UNITY_Q15 : r_row_factor;
    end

    // Configuration, counters and stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= DEF_IMAGE_DIM;
            r_height     <= DEF_IMAGE_DIM;
            r_md         <= DEF_MAX_DARKEN;
            r_col        <= '0;
            r_row        <= '0;
            r_row_factor <= UNITY_Q15;
            r_stg_vld    <= 1'b0;
            r_wait_div   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[CFG_DIM_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_wdata[CFG_DIM_W-1:0];
                    REG_MAX_DARKEN:   r_md     <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_stg_vld <= 1'b1;
                r_col     <= n_col;
                r_row     <= n_row;
                if (x == '0 && !need_div) begin
                    r_row_factor <= UNITY_Q15;
                end
            end else if (stg_push) begin
                r_stg_vld <= 1'b0;
            end
            if (div_start) begin
                r_wait_div <= 1'b1;
            end else if (r_wait_div && !div_busy) begin
                r_wait_div   <= 1'b0;
                r_row_factor <= div_factor;
            end
        end
    end

    // Stage payload; the factor is filled in when the divide completes.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg <= n_stg;
        end else if (r_wait_div && !div_busy) begin
            r_stg.factor <= div_factor;
        end
    end

    gdbd_div #(
        .CW(CW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_k      (k),
        .i_span   (span[CW-1:0]),
        .i_md     (md_sat),
        .o_busy   (div_busy),
        .o_factor (div_factor)
    );

    `ASSERT_NEVER(a_div_idle, i_clk, i_rst_n, div_start && div_busy, "divide started while busy")
    `ASSERT_ALWAYS(a_wait_has_stg, i_clk, i_rst_n, r_wait_div |-> r_stg_vld, "divide wait without stage")

endmodule

`default_nettype wire

@@ rtl/core/gdbd_back.sv @@
`default_nettype none

// Back part: scale, dither, clamp and repack faded pixels, then queue the result.
module gdbd_back import gdbd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_mid_empty,
    input  wire t_mid  i_mid_data,
    output logic       o_mid_rd,
    input  wire logic  i_pop,
    output logic       o_empty,
    output logic [15:0] o_pixel_out,
    output logic       o_frame_end
);

    logic signed [11:0] dith;
    logic signed [18:0] dq_rb;
    logic signed [18:0] dq_g;
    logic [7:0]         r8;
    logic [7:0]         g8;
    logic [7:0]         b8;
    logic [7:0]         ro;
    logic [7:0]         go;
    logic [7:0]         bo;
    logic               out_full;
    t_res               res;
    t_res               out_head;

    // Scale one 8-bit channel by a Q1.15 factor, add the offset, truncate and clamp.
    function automatic logic [7:0] shade(logic [7:0] c8, logic [15:0] f,
                                         logic signed [18:0] dq);
        logic [23:0]        prod;
        logic signed [25:0] s;
        prod = {16'd0, c8} * {8'd0, f};
        s    = $signed({2'b00, prod}) + 26'(dq);
        if (s <= 26'sd0) begin
            return 8'd0;
        end else if (s[25:15] > 11'd255) begin
            return 8'd255;
        end else begin
            return s[22:15];
        end
    endfunction

    // Channel widening and dither offsets; green gets half the offset.
    assign r8    = {i_mid_data.pixel[15:11], 3'b000};
    assign g8    = {i_mid_data.pixel[10:5], 2'b00};
    assign b8    = {i_mid_data.pixel[4:0], 3'b000};
    assign dith  = DITHER_TAB[{i_mid_data.by, i_mid_data.bx}];
    assign dq_rb = {dith, 7'd0};
    assign dq_g  = {dith[11], dith, 6'd0};

    assign ro = shade(r8, i_mid_data.factor, dq_rb);
    assign go = shade(g8, i_mid_data.factor, dq_g);
    assign bo = shade(b8, i_mid_data.factor, dq_rb);

    // Faded rows are repacked, upper rows pass through.
    always_comb begin
        res.frame_end = i_mid_data.frame_end;
        if (i_mid_data.fade) begin
            res.pixel = {ro[7:3], go[7:2], bo[7:3]};
        end else begin
            res.pixel = i_mid_data.pixel;
        end
    end

    assign o_mid_rd = !i_mid_empty && !out_full;

    gdbd_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (o_mid_rd),
        .i_wdata (res),
        .o_full  (out_full),
        .i_rd    (i_pop && !o_empty),
        .o_rdata (out_head),
        .o_empty (o_empty)
    );

    assign o_pixel_out = out_head.pixel;
    assign o_frame_end = out_head.frame_end;

endmodule

`default_nettype wire

@@ rtl/core/gradient_dim_bayer_dither_rgb565.sv @@
// A pixel that is taken passes the front stage register, the request queue and the
// output queue before its result shows on the output. The first pixel of a faded row
// also waits in the stage for the row-factor divide, one quotient bit a cycle. Throughput:
// one pixel per cycle while both queues have room; each faded row start holds the input
// until its divide is done. Reset is synchronous and active low: counters clear, factor is
// unity, both queues empty, registers return to width 1, height 1, darkening 0.8.
`default_nettype none

module gradient_dim_bayer_dither_rgb565 import gdbd_pkg::*; #(
    parameter int MAX_DIM = 2048
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [15:0]           i_pixel_in,
    input  wire logic                  i_frame_start,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [15:0]                o_pixel_out,
    output logic                       o_frame_end,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic mid_wr;
    logic mid_full;
    logic mid_rd;
    logic mid_empty;
    t_mid mid_wdata;
    t_mid mid_rdata;

    gdbd_front #(
        .MAX_DIM(MAX_DIM)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_pixel_in    (i_pixel_in),
        .i_frame_start (i_frame_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_mid_wr      (mid_wr),
        .o_mid_data    (mid_wdata),
        .i_mid_full    (mid_full)
    );

    // Request queue between front and back.
    gdbd_fifo #(
        .WIDTH ($bits(t_mid)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mid_wr),
        .i_wdata (mid_wdata),
        .o_full  (mid_full),
        .i_rd    (mid_rd),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    gdbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_mid_data  (mid_rdata),
        .o_mid_rd    (mid_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end)
    );

endmodule

`default_nettype wire
